FILE: rtl/cmq_pkg.sv
`default_nettype none
package cmq_pkg;

  localparam int RING_SLOTS_DEF = 32;

  localparam int CODE_W  = 8;
  localparam int PARAM_W = 32;
  localparam int COUNT_W = 8;
  localparam int IN_W    = 40;
  localparam int OUT_W   = 56;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_GET  = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0]  code;
    logic [PARAM_W-1:0] param;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
    logic bump;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_GET,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/coalescing_message_queue_unit.sv
`default_nettype none
// Coalescing message queue: a FIFO of up to RING_SLOTS-1 messages held in a ring of cells,
// the oldest always in cell 0. A send rotates the whole ring once, one cell per cycle, and
// compares each queued entry as it passes the last cell, newest first; the first match is
// incremented in flight if its count is below 255, otherwise (no match, or that match is
// saturated) the message is appended with count 1 (or dropped with ok=0 when full). A send
// therefore occupies the block for that full revolution of the ring; a get pops cell 0 and
// shifts the ring down by one. The output register lets the next item be accepted while a
// result waits. Storage needs no clearing after reset.
module coalescing_message_queue_unit
  import cmq_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,   // message_code, message_param
  input  wire logic             s_tuser,   // op
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [OUT_W-1:0]      m_tdata    // ok, merged, out_code, out_param, out_count, pad
);

  localparam int CW = $clog2(RING_SLOTS);
  localparam logic [CW-1:0] LAST = CW'(RING_SLOTS - 1);

  state_t state, state_next;

  logic [CW-1:0]      cnt;
  logic [CW-1:0]      j;
  logic               searching;
  logic               merged_hit;
  logic [CODE_W-1:0]  item_code;
  logic [PARAM_W-1:0] item_param;

  logic               res_ok;
  logic               res_merged;
  logic [CODE_W-1:0]  res_code;
  logic [PARAM_W-1:0] res_param;
  logic [COUNT_W-1:0] res_count;

  entry_t cell_data [RING_SLOTS];
  entry_t cand;
  entry_t new_entry;

  logic hit, bump_en, append_en, pop, out_load, scan_en;

  assign cand      = cell_data[RING_SLOTS-1];
  assign new_entry = '{code: item_code, param: item_param, count: COUNT_W'(1)};
  assign hit       = searching && (j < cnt) &&
                     (cand.code == item_code) && (cand.param == item_param);

  genvar k;
  generate
    for (k = 0; k < RING_SLOTS; k++) begin : g_cell
      localparam int LO = (k + RING_SLOTS - 1) % RING_SLOTS;
      localparam int HI = (k + 1) % RING_SLOTS;
      cell_ctrl_t ctrl;
      assign ctrl.shift_up   = scan_en;
      assign ctrl.shift_down = pop;
      assign ctrl.load       = append_en && (cnt == CW'(k));
      assign ctrl.bump       = (k == 0) && bump_en;
      cmq_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .from_lo   (cell_data[LO]),
        .from_hi   (cell_data[HI]),
        .load_data (new_entry),
        .data      (cell_data[k])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    scan_en    = 1'b0;
    bump_en    = 1'b0;
    append_en  = 1'b0;
    pop        = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = (s_tuser == OP_GET) ? ST_GET : ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_en = 1'b1;
        bump_en = hit && (cand.count != COUNT_MAX);
        if (j == '0) begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND: begin
        append_en  = !merged_hit && (cnt != LAST);
        state_next = ST_DONE;
      end
      ST_GET: begin
        pop        = (cnt != '0);
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      searching  <= 1'b0;
      merged_hit <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        j          <= LAST;
        searching  <= 1'b1;
        merged_hit <= 1'b0;
        item_code  <= s_tdata[CODE_W-1:0];
        item_param <= s_tdata[CODE_W +: PARAM_W];
      end
      if (scan_en) begin
        j <= j - CW'(1);
        // stop at the newest match, merged or saturated
        if (hit) begin
          searching <= 1'b0;
        end
        if (bump_en) begin
          merged_hit <= 1'b1;
        end
      end
      if (state == ST_APPEND) begin
        res_ok     <= merged_hit || append_en;
        res_merged <= merged_hit;
        res_code   <= '0;
        res_param  <= '0;
        res_count  <= '0;
        if (append_en) begin
          cnt <= cnt + CW'(1);
        end
      end
      if (state == ST_GET) begin
        res_ok     <= pop;
        res_merged <= 1'b0;
        res_code   <= pop ? cell_data[0].code  : '0;
        res_param  <= pop ? cell_data[0].param : '0;
        res_count  <= pop ? cell_data[0].count : '0;
        if (pop) begin
          cnt <= cnt - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {6'b0, res_count, res_param, res_code, res_merged, res_ok};
    end
  end

  a_pop_count : assert property (@(posedge clk) disable iff (rst)
    (state == ST_GET && cnt != '0) |=> (cnt == $past(cnt) - CW'(1)))
    else $error("pop did not retire one entry");

  a_scan_end : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && j == '0) |=> (state == ST_APPEND))
    else $error("scan did not end after one revolution");

  a_single_merge : assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && bump_en) |=> (!searching && merged_hit))
    else $error("search kept running after a merge");

  a_merged_ok : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1]) |-> m_tdata[0])
    else $error("merged result without ok");

  a_no_overfill : assert property (@(posedge clk) disable iff (rst)
    (state == ST_APPEND && cnt == LAST) |=> (cnt == LAST))
    else $error("append into a full ring");

endmodule
`default_nettype wire

FILE: rtl/cmq_cell.sv
`default_nettype none
module cmq_cell
  import cmq_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire entry_t     from_lo,
  input  wire entry_t     from_hi,
  input  wire entry_t     load_data,
  output entry_t          data
);

  entry_t bumped;

  always_comb begin
    bumped       = from_lo;
    bumped.count = from_lo.count + COUNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      data <= load_data;
    end else if (ctrl.shift_up) begin
      // merge lands on the entry as it passes the wrap point
      data <= ctrl.bump ? bumped : from_lo;
    end else if (ctrl.shift_down) begin
      data <= from_hi;
    end
  end

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
module tb;
  import cmq_pkg::*;

  localparam int SLOTS = RING_SLOTS_DEF;
  localparam int QUIET_TAIL = 80;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT = 120;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int END_WAIT = 60;
  localparam int ITEM_TARGET = 800;

  typedef logic [$clog2(SLOTS)-1:0] slot_t;

  typedef struct packed {
    logic               op;
    logic [CODE_W-1:0]  code;
    logic [PARAM_W-1:0] param;
    logic               drain;
  } msg_t;

  typedef struct packed {
    logic               ok;
    logic               merged;
    logic [CODE_W-1:0]  code;
    logic [PARAM_W-1:0] param;
    logic [COUNT_W-1:0] count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_W-1:0] s_tdata = '0;  // message_code, message_param
  logic s_tuser = 1'b0;           // op
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;      // ok, merged, out_code, out_param, out_count, pad

  coalescing_message_queue_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the ring contents
  logic [CODE_W-1:0]  ring_code [SLOTS];
  logic [PARAM_W-1:0] ring_param[SLOTS];
  logic [COUNT_W-1:0] ring_count[SLOTS];
  slot_t ring_head = '0;
  slot_t ring_tail = '0;

  msg_t   msgs_to_send[$];
  reply_t replies_due[$];
  int     total_items = 0;
  int     n_sent = 0;
  int     n_recv = 0;
  int     errors = 0;
  logic   drain_next = 1'b0;

  function automatic reply_t mirror_queue_op(logic op, logic [CODE_W-1:0] code,
                                             logic [PARAM_W-1:0] param);
    reply_t r;
    slot_t  i;
    logic   found;
    r = '0;
    found = 1'b0;
    if (op == OP_SEND) begin
      // search newest to oldest, stop at the first matching entry
      i = ring_tail;
      while (i != ring_head && !found) begin
        i = i - 1'b1;
        if (ring_code[i] == code && ring_param[i] == param) begin
          found = 1'b1;
          if (ring_count[i] != COUNT_MAX) begin
            ring_count[i] = ring_count[i] + 1'b1;
            r.ok = 1'b1;
            r.merged = 1'b1;
          end
        end
      end
      if (!r.merged && slot_t'(ring_tail + 1'b1) != ring_head) begin
        ring_code[ring_tail] = code;
        ring_param[ring_tail] = param;
        ring_count[ring_tail] = COUNT_W'(1);
        ring_tail = ring_tail + 1'b1;
        r.ok = 1'b1;
      end
    end else if (ring_head != ring_tail) begin
      r.ok = 1'b1;
      r.code = ring_code[ring_head];
      r.param = ring_param[ring_head];
      r.count = ring_count[ring_head];
      ring_head = ring_head + 1'b1;
    end
    return r;
  endfunction

  task automatic push_msg(logic op, logic [CODE_W-1:0] code, logic [PARAM_W-1:0] param);
    msg_t m;
    m.op = op;
    m.code = code;
    m.param = param;
    m.drain = drain_next;
    drain_next = 1'b0;
    msgs_to_send.push_back(m);
  endtask

  task automatic push_get();
    push_msg(OP_GET, CODE_W'($urandom), $urandom);
  endtask

  // Empty the ring, fill it to the brim, then hit it with repeats and fresh messages, then pop four entries
  task automatic fill_ring();
    logic [CODE_W-1:0]  held_code [SLOTS-1];
    logic [PARAM_W-1:0] held_param[SLOTS-1];
    int k;
    int j;
    for (k = 0; k < SLOTS; k++) push_get();
    for (k = 0; k < SLOTS - 1; k++) begin
      held_code[k] = CODE_W'($urandom);
      held_param[k] = $urandom;
      push_msg(OP_SEND, held_code[k], held_param[k]);
    end
    for (k = 0; k < 12; k++) begin
      if (k % 2 == 0) begin
        j = $urandom_range(0, SLOTS - 2);
        push_msg(OP_SEND, held_code[j], held_param[j]);
      end else begin
        push_msg(OP_SEND, CODE_W'($urandom), $urandom);
      end
    end
    for (k = 0; k < 4; k++) push_get();
  endtask

  // Sender
  msg_t cur_msg;
  int   gap_left = 0;

  always @(posedge clk) begin
    int sent_total;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      sent_total = n_sent;
      if (s_tvalid && s_tready) begin
        replies_due.push_back(mirror_queue_op(cur_msg.op, cur_msg.code, cur_msg.param));
        sent_total = n_sent + 1;
        n_sent <= sent_total;
      end
      if (!(s_tvalid && !s_tready)) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (msgs_to_send.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (msgs_to_send[0].drain && n_recv != sent_total) begin
          // hold until every reply is back
          s_tvalid <= 1'b0;
        end else begin
          cur_msg = msgs_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_msg.op;
          s_tdata <= {cur_msg.param, cur_msg.code};
          if (sent_total < total_items - QUIET_TAIL && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 15);
        end
      end
    end
  end

  // Receiver
  int   stall_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_recv <= n_recv + 1;
        if (replies_due.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = replies_due.pop_front();
          report_field("ok", 32'(want.ok), 32'(m_tdata[0]));
          report_field("merged", 32'(want.merged), 32'(m_tdata[1]));
          report_field("out_code", 32'(want.code), 32'(m_tdata[9:2]));
          report_field("out_param", want.param, m_tdata[41:10]);
          report_field("out_count", 32'(want.count), 32'(m_tdata[49:42]));
        end
      end
      if (!hold_done && n_recv >= HOLD_OFF_AT) begin
        // long back-pressure so the block fills up and stalls its input
        hold_done = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (n_recv < total_items - QUIET_TAIL && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 15);
      end
    end
  end

  // Watchdog on cycles with no item moving
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    logic [CODE_W-1:0]  pool_code [8];
    logic [PARAM_W-1:0] pool_param[8];
    logic [CODE_W-1:0]  c;
    logic [PARAM_W-1:0] p;
    int k;
    int n;
    int phase;
    int send_pct;

    // get on empty, extreme codes and params, merges past a newer entry
    push_get();
    push_msg(OP_SEND, 8'h00, 32'h0000_0000);
    push_msg(OP_SEND, 8'hff, 32'hffff_ffff);
    push_msg(OP_SEND, 8'h00, 32'h0000_0000);
    push_msg(OP_SEND, 8'h00, 32'hffff_ffff);
    push_msg(OP_SEND, 8'hff, 32'h0000_0000);
    push_msg(OP_SEND, 8'hff, 32'hffff_ffff);
    for (k = 0; k < 6; k++) push_get();
    push_msg(OP_SEND, 8'h5a, 32'ha5a5_a5a5);
    push_msg(OP_SEND, 8'h5a, 32'ha5a5_a5a5);
    push_get();
    push_msg(OP_SEND, 8'ha5, 32'h5a5a_5a5a);
    push_get();

    drain_next = 1'b1;
    fill_ring();

    // saturate one count, then the next send of that message starts a new entry
    drain_next = 1'b1;
    for (k = 0; k < SLOTS; k++) push_get();
    c = CODE_W'($urandom);
    p = $urandom;
    for (k = 0; k < 300; k++) push_msg(OP_SEND, c, p);
    for (k = 0; k < 3; k++) push_get();

    pool_code[0] = '0;
    pool_param[0] = '0;
    pool_code[1] = '1;
    pool_param[1] = '1;
    for (k = 2; k < 8; k++) begin
      pool_code[k] = CODE_W'($urandom_range(0, 3));
      pool_param[k] = $urandom_range(0, 3);
    end

    while (msgs_to_send.size() < ITEM_TARGET) begin
      phase = $urandom_range(0, 4);
      n = $urandom_range(20, 50);
      if ($urandom_range(0, 3) == 0) drain_next = 1'b1;
      if (phase == 0) begin
        fill_ring();
      end else begin
        case (phase)
          1: send_pct = 85;
          2: send_pct = 20;
          3: send_pct = 50;
          default: send_pct = 65;
        endcase
        for (k = 0; k < n; k++) begin
          if ($urandom_range(1, 100) > send_pct) begin
            push_get();
          end else if ($urandom_range(0, 9) < 6) begin
            c = pool_code[3'($urandom_range(0, 7))];
            p = pool_param[3'($urandom_range(0, 7))];
            push_msg(OP_SEND, c, p);
          end else begin
            push_msg(OP_SEND, CODE_W'($urandom), $urandom);
          end
        end
      end
    end
    total_items = msgs_to_send.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (n_sent == total_items && n_recv == total_items);
    repeat (END_WAIT) @(posedge clk);
    if (errors == 0 && replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (replies_due.size() != 0)
        $display("%0t: replies missing, expected %0d more, actual 0", $time,
                 replies_due.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
